/* rtl/twvl_pkg.sv */
// Package for the twist velocity limiter: field widths, register indexes, reset values
// and the packed request and response transaction types. It depends on nothing else.
package twvl_pkg;

   localparam int VEL_WIDTH = 16;
   localparam int CFG_WIDTH = 15;
   localparam int MUL_WIDTH = 32;
   localparam int REG_INDEX_WIDTH = 2;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_LINEAR_MAX    = 2'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_LINEAR_MIN    = 2'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ANGULAR_LIMIT = 2'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ANGULAR_STEP  = 2'd3;

   localparam logic [CFG_WIDTH-1:0] LINEAR_MAX_RESET    = 15'd4096;
   localparam logic [CFG_WIDTH-1:0] LINEAR_MIN_RESET    = 15'd0;
   localparam logic [CFG_WIDTH-1:0] ANGULAR_LIMIT_RESET = 15'd4096;
   localparam logic [CFG_WIDTH-1:0] ANGULAR_STEP_RESET  = 15'd410;

   typedef struct packed {
      logic signed [VEL_WIDTH-1:0] in_lin_x;
      logic signed [VEL_WIDTH-1:0] in_lin_y;
      logic signed [VEL_WIDTH-1:0] in_ang_z;
   } req_type;

   typedef struct packed {
      logic signed [VEL_WIDTH-1:0] out_lin_x;
      logic signed [VEL_WIDTH-1:0] out_lin_y;
      logic signed [VEL_WIDTH-1:0] out_ang_z;
   } rsp_type;

endpackage

/* rtl/twist_velocity_limiter.sv */
// Twist velocity limiter: linear magnitude limiting, yaw clamp and yaw slew limiting.
// Depends on twvl_pkg for widths, register indexes and transaction types.
// One transaction at a time: req_ready is high only in the idle state, and the next one is taken
// once the result is registered. A linear vector that passes unchanged skips the rescale, which
// needs two 15-bit quotient searches, one per component, on one shared multiplier.
// Synchronous reset restores the register defaults and clears the previous yaw rate.
module twist_velocity_limiter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  twvl_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output twvl_pkg::rsp_type     rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int VW = twvl_pkg::VEL_WIDTH;
   localparam int CW = twvl_pkg::CFG_WIDTH;
   localparam int MW = twvl_pkg::MUL_WIDTH;
   localparam int BW = $clog2(CW);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQX  = 4'd1;
   localparam logic [3:0] S_SQY  = 4'd2;
   localparam logic [3:0] S_MX2  = 4'd3;
   localparam logic [3:0] S_MN2  = 4'd4;
   localparam logic [3:0] S_DEC  = 4'd5;
   localparam logic [3:0] S_AMUL = 4'd6;
   localparam logic [3:0] S_A2   = 4'd7;
   localparam logic [3:0] S_SEED = 4'd8;
   localparam logic [3:0] S_MUL  = 4'd9;
   localparam logic [3:0] S_CMP  = 4'd10;
   localparam logic [3:0] S_ANG  = 4'd11;

   localparam logic signed [VW+1:0] SAT_HI = (VW+2)'((1 << (VW-1)) - 1);
   localparam logic signed [VW+1:0] SAT_LO = -SAT_HI - (VW+2)'(1);

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       lin_max_ff, lin_min_ff, ang_lim_ff, ang_step_ff;
   logic [VW-1:0]       x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [VW-1:0]       magx_ff, magx_in, magy_ff, magy_in;
   logic [MW-1:0]       sxx_ff, sxx_in, s_ff, s_in, mx2_ff, mx2_in;
   logic [CW-1:0]       lim_ff, lim_in, q_ff, q_in, trial;
   logic                comp_ff, comp_in, take;
   logic [MW-1:0]       qsq_ff, qsq_in, tsq_ff, tsq_in, cand_keep, cand_take, next_bit_sq;
   logic [BW-1:0]       bit_ff, bit_in, bit_m1;
   logic [2*MW-1:0]     a2_ff, a2_in, prod_ff, prod_in;
   logic [MW-1:0]       mul_a, mul_b;
   logic [VW-1:0]       ox_ff, ox_in, oy_ff, oy_in, last_yaw_ff, last_yaw_in, q_signed;
   logic                rsp_valid_ff, rsp_valid_in;
   twvl_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                csr_write;
   logic signed [VW:0]   alim, z_ext, z_clamp;
   logic signed [VW+1:0] p_ext, d_ext, hi_lim, lo_lim, z_wide, oz_wide;
   logic [VW-1:0]       oz;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         twvl_pkg::REG_LINEAR_MAX:    prdata = 32'(lin_max_ff);
         twvl_pkg::REG_LINEAR_MIN:    prdata = 32'(lin_min_ff);
         twvl_pkg::REG_ANGULAR_LIMIT: prdata = 32'(ang_lim_ff);
         twvl_pkg::REG_ANGULAR_STEP:  prdata = 32'(ang_step_ff);
         default:                     prdata = '0;
      endcase
   end

   // Yaw clamp and slew limit against the previous output.
   always_comb begin
      alim    = signed'({2'b00, ang_lim_ff});
      z_ext   = signed'({z_ff[VW-1], z_ff});
      if (z_ext > alim) begin
         z_clamp = alim;
      end else if (z_ext < -alim) begin
         z_clamp = -alim;
      end else begin
         z_clamp = z_ext;
      end
      p_ext  = signed'({{2{last_yaw_ff[VW-1]}}, last_yaw_ff});
      d_ext  = signed'({3'b000, ang_step_ff});
      hi_lim = p_ext + d_ext;
      lo_lim = p_ext - d_ext;
      z_wide = signed'({z_clamp[VW], z_clamp});
      if (z_wide > hi_lim) begin
         oz_wide = hi_lim;
      end else if (z_wide < lo_lim) begin
         oz_wide = lo_lim;
      end else begin
         oz_wide = z_wide;
      end
      if (oz_wide > SAT_HI) begin
         oz = SAT_HI[VW-1:0];
      end else if (oz_wide < SAT_LO) begin
         oz = SAT_LO[VW-1:0];
      end else begin
         oz = oz_wide[VW-1:0];
      end
   end

   // Quotient search: the trial square for the next bit is prepared for both outcomes.
   always_comb begin
      trial       = q_ff | (CW'(1) << bit_ff);
      bit_m1      = bit_ff - BW'(1);
      next_bit_sq = MW'(1) << {bit_m1, 1'b0};
      cand_keep   = qsq_ff + (MW'(q_ff) << bit_ff) + next_bit_sq;
      cand_take   = tsq_ff + (MW'(trial) << bit_ff) + next_bit_sq;
      take        = (trial <= lim_ff) && (prod_ff <= a2_ff);
      q_signed    = (comp_ff ? y_ff[VW-1] : x_ff[VW-1]) ?
                    (VW'(0) - VW'(take ? trial : q_ff)) : VW'(take ? trial : q_ff);
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      magx_in      = magx_ff;
      magy_in      = magy_ff;
      sxx_in       = sxx_ff;
      s_in         = s_ff;
      mx2_in       = mx2_ff;
      lim_in       = lim_ff;
      comp_in      = comp_ff;
      q_in         = q_ff;
      qsq_in       = qsq_ff;
      tsq_in       = tsq_ff;
      bit_in       = bit_ff;
      a2_in        = a2_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      last_yaw_in  = last_yaw_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_data.in_lin_x;
               y_in     = req_data.in_lin_y;
               z_in     = req_data.in_ang_z;
               magx_in  = req_data.in_lin_x[VW-1] ? (VW'(0) - req_data.in_lin_x)
                                                  : req_data.in_lin_x;
               magy_in  = req_data.in_lin_y[VW-1] ? (VW'(0) - req_data.in_lin_y)
                                                  : req_data.in_lin_y;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            mul_a    = MW'(magx_ff);
            mul_b    = MW'(magx_ff);
            state_in = S_SQY;
         end
         S_SQY: begin
            mul_a    = MW'(magy_ff);
            mul_b    = MW'(magy_ff);
            sxx_in   = prod_ff[MW-1:0];
            state_in = S_MX2;
         end
         S_MX2: begin
            mul_a    = MW'(lin_max_ff);
            mul_b    = MW'(lin_max_ff);
            s_in     = sxx_ff + prod_ff[MW-1:0];
            state_in = S_MN2;
         end
         S_MN2: begin
            mul_a    = MW'(lin_min_ff);
            mul_b    = MW'(lin_min_ff);
            mx2_in   = prod_ff[MW-1:0];
            state_in = S_DEC;
         end
         S_DEC: begin
            comp_in = 1'b0;
            ox_in   = x_ff;
            oy_in   = y_ff;
            if (s_ff > mx2_ff) begin
               lim_in   = lin_max_ff;
               state_in = S_AMUL;
            end else if ((s_ff != '0) && ((2*MW)'(s_ff) < prod_ff)) begin
               lim_in   = lin_min_ff;
               state_in = S_AMUL;
            end else begin
               state_in = S_ANG;
            end
         end
         S_AMUL: begin
            mul_a    = MW'(comp_ff ? magy_ff : magx_ff);
            mul_b    = MW'(lim_ff);
            q_in     = '0;
            qsq_in   = '0;
            bit_in   = BW'(CW - 1);
            tsq_in   = MW'(1) << (2 * (CW - 1));
            state_in = S_A2;
         end
         S_A2: begin
            mul_a    = prod_ff[MW-1:0];
            mul_b    = prod_ff[MW-1:0];
            state_in = S_SEED;
         end
         S_SEED: begin
            a2_in    = prod_ff;
            mul_a    = tsq_ff;
            mul_b    = s_ff;
            state_in = S_CMP;
         end
         S_MUL: begin
            mul_a    = tsq_ff;
            mul_b    = s_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (take) begin
               q_in   = trial;
               qsq_in = tsq_ff;
               tsq_in = cand_take;
            end else begin
               tsq_in = cand_keep;
            end
            if (bit_ff == '0) begin
               if (comp_ff) begin
                  oy_in    = q_signed;
                  state_in = S_ANG;
               end else begin
                  ox_in    = q_signed;
                  comp_in  = 1'b1;
                  state_in = S_AMUL;
               end
            end else begin
               bit_in   = bit_m1;
               state_in = S_MUL;
            end
         end
         S_ANG: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.out_lin_x = ox_ff;
               rsp_data_in.out_lin_y = oy_ff;
               rsp_data_in.out_ang_z = oz;
               rsp_valid_in          = 1'b1;
               last_yaw_in           = oz;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_yaw_ff  <= '0;
         lin_max_ff   <= twvl_pkg::LINEAR_MAX_RESET;
         lin_min_ff   <= twvl_pkg::LINEAR_MIN_RESET;
         ang_lim_ff   <= twvl_pkg::ANGULAR_LIMIT_RESET;
         ang_step_ff  <= twvl_pkg::ANGULAR_STEP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_yaw_ff  <= last_yaw_in;
         if (csr_write) begin
            case (paddr[3:2])
               twvl_pkg::REG_LINEAR_MAX:    lin_max_ff  <= pwdata[CW-1:0];
               twvl_pkg::REG_LINEAR_MIN:    lin_min_ff  <= pwdata[CW-1:0];
               twvl_pkg::REG_ANGULAR_LIMIT: ang_lim_ff  <= pwdata[CW-1:0];
               twvl_pkg::REG_ANGULAR_STEP:  ang_step_ff <= pwdata[CW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      magx_ff     <= magx_in;
      magy_ff     <= magy_in;
      sxx_ff      <= sxx_in;
      s_ff        <= s_in;
      mx2_ff      <= mx2_in;
      lim_ff      <= lim_in;
      comp_ff     <= comp_in;
      q_ff        <= q_in;
      qsq_ff      <= qsq_in;
      tsq_ff      <= tsq_in;
      bit_ff      <= bit_in;
      a2_ff       <= a2_in;
      prod_ff     <= prod_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_trial_square: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (tsq_ff == MW'(trial) * MW'(trial)))
      else $error("trial square does not match the trial quotient");

   a_quotient_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (q_ff <= lim_ff))
      else $error("partial quotient exceeds the active bound");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_ANG))
      else $error("result raised outside the yaw stage");

   a_yaw_history: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.out_ang_z == last_yaw_ff))
      else $error("pending yaw rate differs from the stored previous yaw rate");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the twist velocity limiter: directed and random commands under
// several register settings, with results checked against a predictor in a scoreboard class.
// Depends on twvl_pkg and twist_velocity_limiter from the RTL.
module tb_top;

   localparam int VW = twvl_pkg::VEL_WIDTH;
   localparam int CW = twvl_pkg::CFG_WIDTH;
   localparam int IW = twvl_pkg::REG_INDEX_WIDTH;

   class velocity_scoreboard;
      logic [CW-1:0] lin_max;
      logic [CW-1:0] lin_min;
      logic [CW-1:0] ang_limit;
      logic [CW-1:0] ang_step;
      logic signed [VW-1:0] prev_yaw;
      twvl_pkg::rsp_type limited_q[$];
      int failures;

      function new();
         lin_max = twvl_pkg::LINEAR_MAX_RESET;
         lin_min = twvl_pkg::LINEAR_MIN_RESET;
         ang_limit = twvl_pkg::ANGULAR_LIMIT_RESET;
         ang_step = twvl_pkg::ANGULAR_STEP_RESET;
         prev_yaw = '0;
         failures = 0;
      endfunction

      static function logic signed [VW-1:0] saturate(longint v);
         longint top;
         top = (longint'(1) <<< (VW - 1)) - 1;
         if (v > top) begin
            return top[VW-1:0];
         end
         if (v < -top - 1) begin
            return VW'(-top - 1);
         end
         return v[VW-1:0];
      endfunction

      function void set_register(logic [IW-1:0] index, logic [31:0] word);
         case (index)
            twvl_pkg::REG_LINEAR_MAX: begin
               lin_max = word[CW-1:0];
            end
            twvl_pkg::REG_LINEAR_MIN: begin
               lin_min = word[CW-1:0];
            end
            twvl_pkg::REG_ANGULAR_LIMIT: begin
               ang_limit = word[CW-1:0];
            end
            twvl_pkg::REG_ANGULAR_STEP: begin
               ang_step = word[CW-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Largest q not above the bound with q*q*s <= (|c|*bound)^2, signed like c.
      function longint scale_to(longint c, longint unsigned s, longint unsigned bound);
         longint unsigned mag, a2, lo, hi, mid;
         mag = (c < 0) ? -c : c;
         a2 = (mag * bound) * (mag * bound);
         lo = 0;
         hi = bound;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * s <= a2) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         return (c < 0) ? -longint'(lo) : longint'(lo);
      endfunction

      function twvl_pkg::rsp_type limit_command(twvl_pkg::req_type cmd);
         twvl_pkg::rsp_type res;
         longint x, y, z, ox, oy, oz, p, d, lim;
         longint unsigned s, mx2, mn2;
         x = cmd.in_lin_x;
         y = cmd.in_lin_y;
         z = cmd.in_ang_z;
         s = x * x + y * y;
         mx2 = longint'(lin_max) * longint'(lin_max);
         mn2 = longint'(lin_min) * longint'(lin_min);
         ox = x;
         oy = y;
         if (s > mx2) begin
            ox = scale_to(x, s, lin_max);
            oy = scale_to(y, s, lin_max);
         end else if (s > 0 && s < mn2) begin
            ox = scale_to(x, s, lin_min);
            oy = scale_to(y, s, lin_min);
         end
         lim = longint'(ang_limit);
         if (z > lim) begin
            z = lim;
         end else if (z < -lim) begin
            z = -lim;
         end
         p = prev_yaw;
         d = longint'(ang_step);
         if (z > p + d) begin
            oz = p + d;
         end else if (z < p - d) begin
            oz = p - d;
         end else begin
            oz = z;
         end
         prev_yaw = saturate(oz);
         res.out_lin_x = saturate(ox);
         res.out_lin_y = saturate(oy);
         res.out_ang_z = prev_yaw;
         return res;
      endfunction

      function void note_command(twvl_pkg::req_type cmd);
         limited_q.push_back(limit_command(cmd));
      endfunction

      function void check_result(twvl_pkg::rsp_type got);
         twvl_pkg::rsp_type want;
         if (limited_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                     got.out_lin_x, got.out_lin_y, got.out_ang_z);
            return;
         end
         want = limited_q.pop_front();
         if (got.out_lin_x !== want.out_lin_x || got.out_lin_y !== want.out_lin_y ||
             got.out_ang_z !== want.out_ang_z) begin
            failures++;
            $display("%0t: mismatch, expected x=%0d y=%0d z=%0d, actual x=%0d y=%0d z=%0d",
                     $time, want.out_lin_x, want.out_lin_y, want.out_ang_z,
                     got.out_lin_x, got.out_lin_y, got.out_ang_z);
         end
      endfunction

      function int pending();
         return limited_q.size();
      endfunction
   endclass

   typedef enum {READY_STEADY, READY_CHOPPY, READY_SPARSE} ready_mode_type;

   localparam int DIRECTED_CMDS [20][3] = '{
      '{0, 0, 0}, '{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{-32768, 0, -32768},
      '{0, 32767, 0}, '{4096, 0, 4096}, '{2897, 2897, 4096}, '{1024, 0, 4096},
      '{723, 723, 4096}, '{1, 0, 0}, '{0, -1, 0}, '{-3, 4, 0}, '{3000, -2000, -4097},
      '{-100, 50, -4096}, '{1000, 1000, 200}, '{0, 0, 410}, '{0, 0, -32768},
      '{0, 0, 32767}, '{4096, -1, 1}, '{-1, -1, -1}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   twvl_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   twvl_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   velocity_scoreboard book = new();
   int burst_left = 0;

   twist_velocity_limiter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("twist_velocity_limiter verification failed");
      $finish;
   end

   initial begin
      ready_mode_type mode;
      int mode_left;
      mode = READY_STEADY;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            book.check_result(rsp_data);
         end
         if (mode_left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 300);
         end
         mode_left--;
         case (mode)
            READY_STEADY: begin
               rsp_ready <= 1'b1;
            end
            READY_CHOPPY: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   task automatic issue(input twvl_pkg::req_type cmd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data <= cmd;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_command(cmd);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_register(input logic [IW-1:0] index,
                                 input logic [CW-1:0] value);
      logic [31:0] word;
      // The upper bits carry noise, which the block must discard.
      word = ($urandom() & 32'hFFFF_8000) | value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      book.set_register(index, word);
   endtask

   task automatic configure(input logic [CW-1:0] max_speed,
                            input logic [CW-1:0] min_speed,
                            input logic [CW-1:0] yaw_limit,
                            input logic [CW-1:0] yaw_step);
      write_register(twvl_pkg::REG_LINEAR_MAX, max_speed);
      write_register(twvl_pkg::REG_LINEAR_MIN, min_speed);
      write_register(twvl_pkg::REG_ANGULAR_LIMIT, yaw_limit);
      write_register(twvl_pkg::REG_ANGULAR_STEP, yaw_step);
   endtask

   function automatic twvl_pkg::req_type random_command();
      twvl_pkg::req_type cmd;
      int bound, z, p, d, lim;
      bound = $urandom_range(0, 1) ? int'(book.lin_max) : int'(book.lin_min);
      bound = bound + bound / 4 + 2;
      if (bound > 32767) begin
         bound = 32767;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            cmd.in_lin_x = VW'($urandom());
            cmd.in_lin_y = VW'($urandom());
         end
         3, 4, 5, 6, 7: begin
            cmd.in_lin_x = VW'(int'($urandom_range(0, 2 * bound)) - bound);
            cmd.in_lin_y = VW'(int'($urandom_range(0, 2 * bound)) - bound);
         end
         8: begin
            cmd.in_lin_x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
            cmd.in_lin_y = $urandom_range(0, 1) ? 16'sh0000 : 16'($urandom());
         end
         default: begin
            cmd.in_lin_x = '0;
            cmd.in_lin_y = '0;
         end
      endcase
      p = book.prev_yaw;
      d = book.ang_step;
      lim = book.ang_limit;
      case ($urandom_range(0, 5))
         0, 1: begin
            z = int'($urandom_range(0, 65535)) - 32768;
         end
         2, 3: begin
            z = p + ($urandom_range(0, 1) ? d : -d) + int'($urandom_range(0, 4)) - 2;
         end
         4: begin
            z = ($urandom_range(0, 1) ? lim : -lim) + int'($urandom_range(0, 4)) - 2;
         end
         default: begin
            z = $urandom_range(0, 1) ? 32767 : -32768;
         end
      endcase
      cmd.in_ang_z = velocity_scoreboard::saturate(z);
      return cmd;
   endfunction

   task automatic run_random(input int count);
      int pause_at;
      pause_at = $urandom_range(0, count - 1);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            wait_until_idle();
         end
         issue(random_command());
      end
   endtask

   initial begin
      twvl_pkg::req_type cmd;
      int top_speed;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_random(145);
      wait_until_idle();
      configure(15'd4096, 15'd1024, 15'd4096, 15'd410);
      for (int i = 0; i < $size(DIRECTED_CMDS); i++) begin
         cmd.in_lin_x = VW'(DIRECTED_CMDS[i][0]);
         cmd.in_lin_y = VW'(DIRECTED_CMDS[i][1]);
         cmd.in_ang_z = VW'(DIRECTED_CMDS[i][2]);
         issue(cmd);
      end
      wait_until_idle();
      configure(15'd32767, 15'd32767, 15'd32767, 15'd32767);
      run_random(145);
      wait_until_idle();
      configure(15'd0, 15'd0, 15'd0, 15'd0);
      run_random(145);
      wait_until_idle();
      configure(15'd2000, 15'd6000, 15'd1000, 15'd50);
      run_random(145);
      repeat (5) begin
         wait_until_idle();
         top_speed = $urandom_range(0, 12000);
         configure(CW'(top_speed), CW'($urandom_range(0, top_speed)),
                   CW'($urandom_range(0, 32767)), CW'($urandom_range(0, 2000)));
         run_random(145);
      end
      wait_until_idle();
      if (book.failures == 0 && book.pending() == 0) begin
         $display("twist_velocity_limiter verification clean");
      end else begin
         $display("twist_velocity_limiter verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/twvl_pkg.sv
rtl/twist_velocity_limiter.sv
verif/tb_top.sv
